>>> rtl/anti_replay_window_check_assert.svh
// Assertion macros for the anti-replay window check.
// Included by the RTL modules that carry concurrent assertions; no other dependency.
`ifndef ANTI_REPLAY_WINDOW_CHECK_ASSERT_SVH
`define ANTI_REPLAY_WINDOW_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is asserted
`define ARW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check, active during reset as well
`define ARW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ARW_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARW_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/arw_pkg.sv
// Shared types and constants of the anti-replay window check.
// No dependencies; used by the interfaces, arw_check and the top level.
`default_nettype none

package arw_pkg;

	localparam int SEQ_W      = 32;
	localparam int WIN_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_REPLAY_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd1;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_OLD    = 2'd1,
		VERDICT_DUP    = 2'd2
	} verdict_t;

	typedef struct packed {
		logic             enable;
		logic [WIN_W-1:0] window;
	} arw_cfg_t;

	typedef struct packed {
		verdict_t         verdict;
		logic             update;
		logic [SEQ_W-1:0] highest;
	} arw_decision_t;

endpackage

`default_nettype wire

>>> rtl/arw_intf.sv
// Handshake channels of the anti-replay window check: packet, result, config.
// Depends on arw_pkg for field widths and the verdict type.
`default_nettype none

interface arw_seq_if;
	logic                      valid;
	logic                      ready;
	logic [arw_pkg::SEQ_W-1:0] seq_num;

	modport source (output valid, output seq_num, input ready);
	modport sink (input valid, input seq_num, output ready);
endinterface

interface arw_res_if;
	logic                      valid;
	logic                      ready;
	arw_pkg::verdict_t         verdict;
	logic [arw_pkg::SEQ_W-1:0] highest_seen;

	modport source (output valid, output verdict, output highest_seen, input ready);
	modport sink (input valid, input verdict, input highest_seen, output ready);
endinterface

interface arw_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [arw_pkg::CFG_IDX_W-1:0]  index;
	logic [arw_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/arw_check.sv
// Verdict logic of the anti-replay window check: window test, duplicate test, new highest.
// Depends on arw_pkg; instantiated by anti_replay_window_check.
`default_nettype none

module arw_check #(
	parameter int WINDOW_BITS = 256
) (
	input  arw_pkg::arw_cfg_t          cfg,
	input  logic [arw_pkg::SEQ_W-1:0]  seq,
	input  logic [arw_pkg::SEQ_W-1:0]  highest,
	input  logic                       seen,
	output arw_pkg::arw_decision_t     decision
);
	import arw_pkg::*;

	localparam int WIN_MAX = (1 << WIN_W) - 1;
	localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'((WINDOW_BITS < WIN_MAX) ? WINDOW_BITS : WIN_MAX);

	logic [WIN_W-1:0] win_eff;
	logic             active;
	logic             newer;
	logic             older;
	logic [SEQ_W-1:0] age;
	logic             too_old;
	logic             dup;

	always_comb begin
		win_eff = (cfg.window > WIN_CAP) ? WIN_CAP : cfg.window;
		active  = cfg.enable && (win_eff != '0);
		newer   = seq > highest;
		older   = seq < highest;
		age     = highest - seq;
		too_old = older && (age >= {{(SEQ_W-WIN_W){1'b0}}, win_eff});
		// a number above the highest lands on a freshly aged slot
		dup     = seen && !newer;

		decision.update  = active && !too_old && !dup;
		decision.highest = (decision.update && newer) ? seq : highest;
		priority if (!active) begin
			decision.verdict = VERDICT_ACCEPT;
		end else if (too_old) begin
			decision.verdict = VERDICT_OLD;
		end else if (dup) begin
			decision.verdict = VERDICT_DUP;
		end else begin
			decision.verdict = VERDICT_ACCEPT;
		end
	end

endmodule

`default_nettype wire

>>> rtl/anti_replay_window_check.sv
// Top level of the anti-replay window check: config registers, tag memory, result register.
// Depends on arw_pkg, the arw_*_if interfaces, arw_check and the assertion macro header.
`default_nettype none
`include "anti_replay_window_check_assert.svh"

// Checks the sequence number of each received packet against a sliding window
// below the highest number seen so far and returns accepted, too old or duplicate,
// with the highest number after the packet. Seen numbers are kept as tags in a
// memory of 2**ceil(log2(WINDOW_BITS)) entries addressed by the low bits of the
// number, so sliding the window costs nothing. One packet is taken every cycle unless a
// result waits unread; a packet is read into the stage-1 registers and its result into
// the result register by the single read-modify-write pass over the tag memory (read at
// accept, write as the result is registered, forwarded when the next packet hits the
// same entry). After reset a clearing pass over all entries holds pkt.ready low. The
// config port is always ready; write it only while no packet is in flight.
module anti_replay_window_check #(
	parameter int WINDOW_BITS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	arw_cfg_if.sink    cfg,
	arw_seq_if.sink    pkt,
	arw_res_if.source  res
);
	import arw_pkg::*;

	localparam int AW    = $clog2(WINDOW_BITS);
	localparam int DEPTH = 1 << AW;
	localparam int TAG_W = SEQ_W - AW;

	arw_cfg_t         cfg_q;
	logic [SEQ_W-1:0] highest_q;

	logic             clr_busy_q;
	logic [AW-1:0]    clr_addr_q;

	// tag memory entry: valid bit over the upper bits of the number
	logic [TAG_W:0]   mem [DEPTH];

	logic             valid_s1;
	logic [SEQ_W-1:0] seq_s1;
	logic [TAG_W:0]   entry_s1;

	logic             res_valid_q;
	verdict_t         res_verdict_q;
	logic [SEQ_W-1:0] res_highest_q;

	logic             s1_fire;
	logic             in_fire;
	logic             seen;
	arw_decision_t    dec;
	logic             mem_we;
	logic [AW-1:0]    wr_addr;
	logic [TAG_W:0]   wr_data;
	logic [AW-1:0]    rd_addr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_REPLAY_ENABLE: cfg_q.enable <= cfg.data[0];
				CFG_WINDOW_SIZE:   cfg_q.window <= cfg.data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign s1_fire   = valid_s1 && (!res_valid_q || res.ready);
	assign pkt.ready = !clr_busy_q && (!valid_s1 || s1_fire);
	assign in_fire   = pkt.valid && pkt.ready;
	assign rd_addr   = pkt.seq_num[AW-1:0];

	assign seen = entry_s1[TAG_W] && (entry_s1[TAG_W-1:0] == seq_s1[SEQ_W-1:AW]);

	arw_check #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_check (
		.cfg      (cfg_q),
		.seq      (seq_s1),
		.highest  (highest_q),
		.seen     (seen),
		.decision (dec)
	);

	always_comb begin
		if (clr_busy_q) begin
			mem_we  = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			mem_we  = s1_fire && dec.update;
			wr_addr = seq_s1[AW-1:0];
			wr_data = {1'b1, seq_s1[SEQ_W-1:AW]};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read at accept; take the write of the same edge when it hits this entry
	always_ff @(posedge clk) begin
		if (in_fire) begin
			seq_s1 <= pkt.seq_num;
			if (mem_we && (wr_addr == rd_addr)) begin
				entry_s1 <= wr_data;
			end else begin
				entry_s1 <= mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			highest_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				highest_q   <= dec.highest;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_verdict_q <= dec.verdict;
			res_highest_q <= dec.highest;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.verdict      = res_verdict_q;
	assign res.highest_seen = res_highest_q;

	`ARW_ASSERT(a_highest_mono, clk, arst_n, 1 |=> (highest_q >= $past(highest_q)), "highest number went down")
	`ARW_ASSERT(a_old_no_update, clk, arst_n, (s1_fire && (dec.verdict == VERDICT_OLD)) |=> $stable(highest_q), "too old packet moved the highest number")
	`ARW_ASSERT(a_dup_not_newer, clk, arst_n, (valid_s1 && (dec.verdict == VERDICT_DUP)) |-> (seq_s1 <= highest_q), "duplicate above the highest number")
	`ARW_ASSERT(a_clear_empty, clk, arst_n, clr_busy_q |-> (!valid_s1 && !res_valid_q), "packet in flight during clearing pass")

endmodule

`default_nettype wire
